### sv/lsmpks_pkg.sv
`timescale 1ns / 1ps

package lsmpks_pkg;

    // Store geometry
    localparam int MEM_CAP    = 64;
    localparam int RUN_LIMIT  = 4;
    localparam int BASE_CAP   = 4096;
    localparam int VALUE_BITS = 32;
    localparam int SLOTS      = RUN_LIMIT - 1;

    // Field widths
    localparam int KEY_W  = 31;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int THR_W  = 7;

    // Derived widths
    localparam int FILL_W    = $clog2(MEM_CAP + 1);
    localparam int MIDX_W    = $clog2(MEM_CAP);
    localparam int SLOT_W    = $clog2(RUN_LIMIT);
    localparam int RUN_DEPTH = RUN_LIMIT * MEM_CAP;
    localparam int RUN_AW    = $clog2(RUN_DEPTH);
    localparam int BFILL_W   = $clog2(BASE_CAP + 1);
    localparam int BASE_AW   = $clog2(BASE_CAP);
    localparam int SIDX_W    = BFILL_W;
    localparam int RUN_W     = KEY_W + VALUE_BITS + 1;
    localparam int BASE_W    = KEY_W + VALUE_BITS;

    // Run RAM slot that holds the memtable
    localparam logic [SLOT_W-1:0] MEM_SLOT = SLOT_W'(SLOTS);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DUP       = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

    // Register map
    localparam int PADDR_W = 3;
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic [THR_W-1:0] THR_RESET = 7'd64;

    // RAM request bundles
    typedef struct packed {
        logic              we;
        logic [RUN_AW-1:0] waddr;
        logic [RUN_W-1:0]  wdata;
        logic [RUN_AW-1:0] raddr;
    } run_req_t;

    typedef struct packed {
        logic               we;
        logic [BASE_AW-1:0] waddr;
        logic [BASE_W-1:0]  wdata;
        logic [BASE_AW-1:0] raddr;
    } base_req_t;

    // Run RAM address of entry idx in slot
    function automatic logic [RUN_AW-1:0] run_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [MIDX_W-1:0] idx);
        run_addr = RUN_AW'(slot) * RUN_AW'(MEM_CAP) + RUN_AW'(idx);
    endfunction

endpackage

### sv/lsmpks_ram.sv
`timescale 1ns / 1ps

module lsmpks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/lsmpks_core.sv
`timescale 1ns / 1ps

module lsmpks_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [lsmpks_pkg::CMD_W-1:0]        command,
    input  logic [lsmpks_pkg::KEY_W-1:0]        key,
    input  logic [31:0]                         payload,
    input  logic [lsmpks_pkg::THR_W-1:0]        thr,
    output logic                                busy,
    output logic                                done,
    output logic [lsmpks_pkg::STAT_W-1:0]       status,
    output logic                                found,
    output logic [31:0]                         value_out,
    output logic [6:0]                          mem_count,
    output logic [2:0]                          run_count,
    output lsmpks_pkg::run_req_t                run_req,
    input  logic [lsmpks_pkg::RUN_W-1:0]        run_rdata,
    output lsmpks_pkg::base_req_t               base_req,
    input  logic [lsmpks_pkg::BASE_W-1:0]       base_rdata
);

    localparam int KW = lsmpks_pkg::KEY_W;
    localparam int VW = lsmpks_pkg::VALUE_BITS;
    localparam int FW = lsmpks_pkg::FILL_W;
    localparam int SW = lsmpks_pkg::SLOT_W;
    localparam int IW = lsmpks_pkg::SIDX_W;
    localparam int BW = lsmpks_pkg::BFILL_W;
    localparam int MW = lsmpks_pkg::MIDX_W;
    localparam int AW = lsmpks_pkg::BASE_AW;

    typedef enum logic [4:0] {
        S_IDLE, S_SRD, S_SCMP, S_ACT, S_PUT, S_SHRD, S_SHWR, S_PUTW, S_PUTCHK,
        S_FLUSH, S_CPRD, S_CPWR, S_CMNEXT, S_CMRD, S_CMLAT, S_BAPPLY, S_BWR, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_RES_MEM, PH_RES_SMALL, PH_RES_BASE, PH_APPLY
    } phase_t;

    state_t state_reg;
    phase_t phase_reg;

    logic [lsmpks_pkg::CMD_W-1:0]  cmd_reg;
    logic [KW-1:0]                 key_reg;
    logic [VW-1:0]                 pay_reg;
    logic [FW-1:0]                 mem_fill_reg;
    logic [FW-1:0]                 sfill_reg [lsmpks_pkg::SLOTS];
    logic [SW-1:0]                 srh_reg;
    logic [BW-1:0]                 base_fill_reg;
    logic [BW-1:0]                 live_reg;
    logic                          had_reg;
    logic [VW-1:0]                 cur_reg;
    logic [lsmpks_pkg::STAT_W-1:0] stat_reg;
    logic [FW-1:0]                 mem_i_reg;
    logic                          mem_hit_reg;
    logic                          s_tgt_reg;
    logic [SW-1:0]                 s_slot_reg;
    logic [IW-1:0]                 s_lo_reg;
    logic [IW-1:0]                 s_hi_reg;
    logic [IW-1:0]                 s_mid_reg;
    logic                          s_hit_reg;
    logic [VW-1:0]                 s_val_reg;
    logic                          s_dead_reg;
    logic [KW-1:0]                 s_key_reg;
    logic [SW-1:0]                 rs_reg;
    logic [VW-1:0]                 put_val_reg;
    logic                          put_dead_reg;
    logic                          sh_tgt_reg;
    logic                          sh_up_reg;
    logic [SW-1:0]                 sh_slot_reg;
    logic [IW-1:0]                 sh_idx_reg;
    logic [IW-1:0]                 sh_lim_reg;
    logic                          fl_pre_reg;
    logic [FW-1:0]                 ci_reg;
    logic [SW-1:0]                 cs_reg;
    logic [KW-1:0]                 ap_key_reg;
    logic [VW-1:0]                 ap_val_reg;
    logic                          ap_dead_reg;
    logic                          done_reg;
    logic [lsmpks_pkg::STAT_W-1:0] status_reg;
    logic                          found_reg;
    logic [31:0]                   value_reg;
    logic [6:0]                    mcount_reg;
    logic [2:0]                    rcount_reg;

    // Read data fields
    logic [KW-1:0] r_key;
    logic [VW-1:0] r_val;
    logic          r_dead;
    logic [KW-1:0] b_key;
    logic [VW-1:0] b_val;
    logic [KW-1:0] cmp_key;

    assign r_key   = run_rdata[KW-1:0];
    assign r_val   = run_rdata[KW +: VW];
    assign r_dead  = run_rdata[lsmpks_pkg::RUN_W-1];
    assign b_key   = base_rdata[KW-1:0];
    assign b_val   = base_rdata[KW +: VW];
    assign cmp_key = s_tgt_reg ? b_key : r_key;

    // Binary search midpoint
    logic [IW:0]   mid_sum;
    logic [IW-1:0] mid;
    assign mid_sum = {1'b0, s_lo_reg} + {1'b0, s_hi_reg};
    assign mid     = mid_sum[IW:1];

    // Effective flush threshold, clamped to 1..MEM_CAP
    logic [FW-1:0] thr_eff;
    always_comb
    begin
        if (thr == '0)
        begin
            thr_eff = FW'(1);
        end
        else if (int'(thr) > lsmpks_pkg::MEM_CAP)
        begin
            thr_eff = FW'(lsmpks_pkg::MEM_CAP);
        end
        else
        begin
            thr_eff = FW'(thr);
        end
    end

    // Runs held: small runs plus a non-empty base
    logic [SW:0] runs_now;
    assign runs_now = {1'b0, srh_reg} + {{SW{1'b0}}, (base_fill_reg != '0)};

    // Action decode after resolve
    logic                          act_put;
    logic [VW-1:0]                 act_val;
    logic                          act_dead;
    logic [lsmpks_pkg::STAT_W-1:0] act_stat;
    logic                          act_inc;
    logic                          act_dec;
    always_comb
    begin
        act_put  = 1'b0;
        act_val  = pay_reg;
        act_dead = 1'b0;
        act_stat = lsmpks_pkg::STAT_OK;
        act_inc  = 1'b0;
        act_dec  = 1'b0;
        case (cmd_reg)
            lsmpks_pkg::CMD_INSERT:
            begin
                if (had_reg)
                begin
                    act_stat = lsmpks_pkg::STAT_DUP;
                end
                else if (int'(live_reg) >= lsmpks_pkg::BASE_CAP)
                begin
                    act_stat = lsmpks_pkg::STAT_FULL;
                end
                else
                begin
                    act_put = 1'b1;
                    act_inc = 1'b1;
                end
            end
            lsmpks_pkg::CMD_UPDATE:
            begin
                if (!had_reg)
                begin
                    act_stat = lsmpks_pkg::STAT_NOT_FOUND;
                end
                else
                begin
                    act_put = 1'b1;
                end
            end
            lsmpks_pkg::CMD_DELETE:
            begin
                if (!had_reg)
                begin
                    act_stat = lsmpks_pkg::STAT_NOT_FOUND;
                end
                else
                begin
                    act_put  = 1'b1;
                    act_val  = '0;
                    act_dead = 1'b1;
                    act_dec  = (live_reg != '0);
                end
            end
            lsmpks_pkg::CMD_LOOKUP:
            begin
                if (!had_reg)
                begin
                    act_stat = lsmpks_pkg::STAT_NOT_FOUND;
                end
            end
            default:
            begin
                act_stat = lsmpks_pkg::STAT_OK;
            end
        endcase
    end

    // Where a flush returns to
    state_t ret_state;
    assign ret_state = fl_pre_reg ? S_PUT : S_DONE;

    // Shift destination
    logic [IW-1:0] sh_dest;
    assign sh_dest = sh_up_reg ? sh_idx_reg + IW'(1) : sh_idx_reg - IW'(1);

    // RAM port control
    always_comb
    begin
        run_req  = '0;
        base_req = '0;
        case (state_reg)
            S_SRD:
            begin
                run_req.raddr  = lsmpks_pkg::run_addr(s_slot_reg, mid[MW-1:0]);
                base_req.raddr = mid[AW-1:0];
            end
            S_SHRD:
            begin
                run_req.raddr  = lsmpks_pkg::run_addr(sh_slot_reg, sh_idx_reg[MW-1:0]);
                base_req.raddr = sh_idx_reg[AW-1:0];
            end
            S_SHWR:
            begin
                if (sh_tgt_reg)
                begin
                    base_req.we    = 1'b1;
                    base_req.waddr = sh_dest[AW-1:0];
                    base_req.wdata = base_rdata;
                end
                else
                begin
                    run_req.we    = 1'b1;
                    run_req.waddr = lsmpks_pkg::run_addr(sh_slot_reg, sh_dest[MW-1:0]);
                    run_req.wdata = run_rdata;
                end
            end
            S_PUTW:
            begin
                run_req.we    = 1'b1;
                run_req.waddr = lsmpks_pkg::run_addr(lsmpks_pkg::MEM_SLOT, mem_i_reg[MW-1:0]);
                run_req.wdata = {put_dead_reg, put_val_reg, key_reg};
            end
            S_CPRD:
            begin
                run_req.raddr = lsmpks_pkg::run_addr(lsmpks_pkg::MEM_SLOT, ci_reg[MW-1:0]);
            end
            S_CPWR:
            begin
                run_req.we    = 1'b1;
                run_req.waddr = lsmpks_pkg::run_addr(srh_reg, ci_reg[MW-1:0]);
                run_req.wdata = run_rdata;
            end
            S_CMRD:
            begin
                run_req.raddr = lsmpks_pkg::run_addr(cs_reg, ci_reg[MW-1:0]);
            end
            S_BAPPLY:
            begin
                if (!ap_dead_reg && s_hit_reg)
                begin
                    base_req.we    = 1'b1;
                    base_req.waddr = s_lo_reg[AW-1:0];
                    base_req.wdata = {ap_val_reg, ap_key_reg};
                end
            end
            S_BWR:
            begin
                base_req.we    = 1'b1;
                base_req.waddr = s_lo_reg[AW-1:0];
                base_req.wdata = {ap_val_reg, ap_key_reg};
            end
            default:
            begin
                run_req = '0;
            end
        endcase
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_RES_MEM;
            cmd_reg       <= '0;
            key_reg       <= '0;
            pay_reg       <= '0;
            mem_fill_reg  <= '0;
            for (int s = 0; s < lsmpks_pkg::SLOTS; s++)
            begin
                sfill_reg[s] <= '0;
            end
            srh_reg       <= '0;
            base_fill_reg <= '0;
            live_reg      <= '0;
            had_reg       <= 1'b0;
            cur_reg       <= '0;
            stat_reg      <= lsmpks_pkg::STAT_OK;
            mem_i_reg     <= '0;
            mem_hit_reg   <= 1'b0;
            s_tgt_reg     <= 1'b0;
            s_slot_reg    <= '0;
            s_lo_reg      <= '0;
            s_hi_reg      <= '0;
            s_mid_reg     <= '0;
            s_hit_reg     <= 1'b0;
            s_val_reg     <= '0;
            s_dead_reg    <= 1'b0;
            s_key_reg     <= '0;
            rs_reg        <= '0;
            put_val_reg   <= '0;
            put_dead_reg  <= 1'b0;
            sh_tgt_reg    <= 1'b0;
            sh_up_reg     <= 1'b0;
            sh_slot_reg   <= '0;
            sh_idx_reg    <= '0;
            sh_lim_reg    <= '0;
            fl_pre_reg    <= 1'b0;
            ci_reg        <= '0;
            cs_reg        <= '0;
            ap_key_reg    <= '0;
            ap_val_reg    <= '0;
            ap_dead_reg   <= 1'b0;
            done_reg      <= 1'b0;
            status_reg    <= lsmpks_pkg::STAT_OK;
            found_reg     <= 1'b0;
            value_reg     <= '0;
            mcount_reg    <= '0;
            rcount_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= command;
                        key_reg   <= key;
                        pay_reg   <= payload;
                        had_reg   <= 1'b0;
                        cur_reg   <= '0;
                        s_key_reg <= key;
                        if (command <= lsmpks_pkg::CMD_LOOKUP)
                        begin
                            // Newest first: memtable
                            s_tgt_reg  <= 1'b0;
                            s_slot_reg <= lsmpks_pkg::MEM_SLOT;
                            s_lo_reg   <= '0;
                            s_hi_reg   <= IW'(mem_fill_reg);
                            s_hit_reg  <= 1'b0;
                            phase_reg  <= PH_RES_MEM;
                            state_reg  <= S_SRD;
                        end
                        else
                        begin
                            state_reg <= S_ACT;
                        end
                    end
                end

                S_SRD:
                begin
                    if (s_lo_reg < s_hi_reg)
                    begin
                        s_mid_reg <= mid;
                        state_reg <= S_SCMP;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_RES_MEM, PH_RES_SMALL:
                            begin
                                if (phase_reg == PH_RES_MEM)
                                begin
                                    mem_i_reg   <= FW'(s_lo_reg);
                                    mem_hit_reg <= s_hit_reg;
                                end
                                if (s_hit_reg)
                                begin
                                    had_reg   <= !s_dead_reg;
                                    cur_reg   <= s_val_reg;
                                    state_reg <= S_ACT;
                                end
                                else if ((phase_reg == PH_RES_MEM && srh_reg != '0) ||
                                         (phase_reg == PH_RES_SMALL && rs_reg != '0))
                                begin
                                    // Next older small run
                                    if (phase_reg == PH_RES_MEM)
                                    begin
                                        rs_reg     <= srh_reg - SW'(1);
                                        s_slot_reg <= srh_reg - SW'(1);
                                        s_hi_reg   <= IW'(sfill_reg[srh_reg - SW'(1)]);
                                    end
                                    else
                                    begin
                                        rs_reg     <= rs_reg - SW'(1);
                                        s_slot_reg <= rs_reg - SW'(1);
                                        s_hi_reg   <= IW'(sfill_reg[rs_reg - SW'(1)]);
                                    end
                                    s_tgt_reg <= 1'b0;
                                    s_lo_reg  <= '0;
                                    s_hit_reg <= 1'b0;
                                    phase_reg <= PH_RES_SMALL;
                                    state_reg <= S_SRD;
                                end
                                else
                                begin
                                    // Oldest: base run
                                    s_tgt_reg <= 1'b1;
                                    s_lo_reg  <= '0;
                                    s_hi_reg  <= base_fill_reg;
                                    s_hit_reg <= 1'b0;
                                    phase_reg <= PH_RES_BASE;
                                    state_reg <= S_SRD;
                                end
                            end
                            PH_RES_BASE:
                            begin
                                had_reg   <= s_hit_reg;
                                cur_reg   <= s_val_reg;
                                state_reg <= S_ACT;
                            end
                            default:
                            begin
                                state_reg <= S_BAPPLY;
                            end
                        endcase
                    end
                end

                S_SCMP:
                begin
                    if (cmp_key < s_key_reg)
                    begin
                        s_lo_reg <= s_mid_reg + IW'(1);
                    end
                    else
                    begin
                        s_hi_reg <= s_mid_reg;
                    end
                    if (cmp_key == s_key_reg)
                    begin
                        s_hit_reg  <= 1'b1;
                        s_val_reg  <= s_tgt_reg ? b_val : r_val;
                        s_dead_reg <= s_tgt_reg ? 1'b0 : r_dead;
                    end
                    state_reg <= S_SRD;
                end

                S_ACT:
                begin
                    stat_reg  <= act_stat;
                    state_reg <= S_DONE;
                    if (act_inc)
                    begin
                        live_reg <= live_reg + BW'(1);
                    end
                    if (act_dec)
                    begin
                        live_reg <= live_reg - BW'(1);
                    end
                    if (cmd_reg == lsmpks_pkg::CMD_FLUSH)
                    begin
                        fl_pre_reg <= 1'b0;
                        state_reg  <= S_FLUSH;
                    end
                    else if (act_put)
                    begin
                        put_val_reg  <= act_val;
                        put_dead_reg <= act_dead;
                        if (!mem_hit_reg && int'(mem_fill_reg) >= lsmpks_pkg::MEM_CAP)
                        begin
                            fl_pre_reg <= 1'b1;
                            state_reg  <= S_FLUSH;
                        end
                        else
                        begin
                            state_reg <= S_PUT;
                        end
                    end
                end

                S_PUT:
                begin
                    if (!mem_hit_reg && mem_i_reg < mem_fill_reg)
                    begin
                        // Open a hole at the insert point
                        sh_tgt_reg  <= 1'b0;
                        sh_up_reg   <= 1'b1;
                        sh_slot_reg <= lsmpks_pkg::MEM_SLOT;
                        sh_idx_reg  <= IW'(mem_fill_reg) - IW'(1);
                        sh_lim_reg  <= IW'(mem_i_reg);
                        state_reg   <= S_SHRD;
                    end
                    else
                    begin
                        state_reg <= S_PUTW;
                    end
                end

                S_SHRD:
                begin
                    state_reg <= S_SHWR;
                end

                S_SHWR:
                begin
                    if (sh_idx_reg == sh_lim_reg)
                    begin
                        if (!sh_tgt_reg)
                        begin
                            state_reg <= S_PUTW;
                        end
                        else if (sh_up_reg)
                        begin
                            state_reg <= S_BWR;
                        end
                        else
                        begin
                            state_reg <= S_CMNEXT;
                        end
                    end
                    else
                    begin
                        sh_idx_reg <= sh_up_reg ? sh_idx_reg - IW'(1) : sh_idx_reg + IW'(1);
                        state_reg  <= S_SHRD;
                    end
                end

                S_PUTW:
                begin
                    if (!mem_hit_reg)
                    begin
                        mem_fill_reg <= mem_fill_reg + FW'(1);
                    end
                    state_reg <= S_PUTCHK;
                end

                S_PUTCHK:
                begin
                    if (mem_fill_reg >= thr_eff)
                    begin
                        fl_pre_reg <= 1'b0;
                        state_reg  <= S_FLUSH;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end

                S_FLUSH:
                begin
                    ci_reg <= '0;
                    cs_reg <= '0;
                    if (mem_fill_reg == '0)
                    begin
                        mem_i_reg   <= '0;
                        mem_hit_reg <= 1'b0;
                        state_reg   <= ret_state;
                    end
                    else if (int'(runs_now) + 1 >= lsmpks_pkg::RUN_LIMIT ||
                             int'(srh_reg) >= lsmpks_pkg::SLOTS)
                    begin
                        state_reg <= S_CMNEXT;
                    end
                    else
                    begin
                        state_reg <= S_CPRD;
                    end
                end

                S_CPRD:
                begin
                    state_reg <= S_CPWR;
                end

                S_CPWR:
                begin
                    if (ci_reg == mem_fill_reg - FW'(1))
                    begin
                        sfill_reg[srh_reg] <= mem_fill_reg;
                        srh_reg            <= srh_reg + SW'(1);
                        mem_fill_reg       <= '0;
                        mem_i_reg          <= '0;
                        mem_hit_reg        <= 1'b0;
                        state_reg          <= ret_state;
                    end
                    else
                    begin
                        ci_reg    <= ci_reg + FW'(1);
                        state_reg <= S_CPRD;
                    end
                end

                S_CMNEXT:
                begin
                    if (cs_reg == lsmpks_pkg::MEM_SLOT)
                    begin
                        if (ci_reg < mem_fill_reg)
                        begin
                            state_reg <= S_CMRD;
                        end
                        else
                        begin
                            for (int s = 0; s < lsmpks_pkg::SLOTS; s++)
                            begin
                                sfill_reg[s] <= '0;
                            end
                            srh_reg      <= '0;
                            mem_fill_reg <= '0;
                            mem_i_reg    <= '0;
                            mem_hit_reg  <= 1'b0;
                            state_reg    <= ret_state;
                        end
                    end
                    else if (cs_reg < srh_reg)
                    begin
                        if (ci_reg < sfill_reg[cs_reg])
                        begin
                            state_reg <= S_CMRD;
                        end
                        else
                        begin
                            cs_reg <= cs_reg + SW'(1);
                            ci_reg <= '0;
                        end
                    end
                    else
                    begin
                        cs_reg <= lsmpks_pkg::MEM_SLOT;
                        ci_reg <= '0;
                    end
                end

                S_CMRD:
                begin
                    state_reg <= S_CMLAT;
                end

                S_CMLAT:
                begin
                    ap_key_reg  <= r_key;
                    ap_val_reg  <= r_val;
                    ap_dead_reg <= r_dead;
                    ci_reg      <= ci_reg + FW'(1);
                    s_tgt_reg   <= 1'b1;
                    s_lo_reg    <= '0;
                    s_hi_reg    <= base_fill_reg;
                    s_hit_reg   <= 1'b0;
                    s_key_reg   <= r_key;
                    phase_reg   <= PH_APPLY;
                    state_reg   <= S_SRD;
                end

                S_BAPPLY:
                begin
                    state_reg <= S_CMNEXT;
                    if (ap_dead_reg)
                    begin
                        // Tombstone removes the base entry and closes the gap
                        if (s_hit_reg)
                        begin
                            base_fill_reg <= base_fill_reg - BW'(1);
                            if (s_lo_reg + IW'(1) < base_fill_reg)
                            begin
                                sh_tgt_reg <= 1'b1;
                                sh_up_reg  <= 1'b0;
                                sh_idx_reg <= s_lo_reg + IW'(1);
                                sh_lim_reg <= base_fill_reg - BW'(1);
                                state_reg  <= S_SHRD;
                            end
                        end
                    end
                    else if (!s_hit_reg && int'(base_fill_reg) < lsmpks_pkg::BASE_CAP)
                    begin
                        if (s_lo_reg < base_fill_reg)
                        begin
                            sh_tgt_reg <= 1'b1;
                            sh_up_reg  <= 1'b1;
                            sh_idx_reg <= base_fill_reg - BW'(1);
                            sh_lim_reg <= s_lo_reg;
                            state_reg  <= S_SHRD;
                        end
                        else
                        begin
                            state_reg <= S_BWR;
                        end
                    end
                end

                S_BWR:
                begin
                    base_fill_reg <= base_fill_reg + BW'(1);
                    state_reg     <= S_CMNEXT;
                end

                S_DONE:
                begin
                    done_reg   <= 1'b1;
                    status_reg <= stat_reg;
                    found_reg  <= had_reg;
                    value_reg  <= had_reg ? 32'(cur_reg) : 32'd0;
                    mcount_reg <= 7'(mem_fill_reg);
                    rcount_reg <= 3'(runs_now);
                    state_reg  <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign value_out = value_reg;
    assign mem_count = mcount_reg;
    assign run_count = rcount_reg;

endmodule

### sv/lsm_point_key_store.sv
`timescale 1ns / 1ps
// A lookup binary-searches the memtable, each small run and the base run, newest first,
// stopping at the first hit, then decodes the action and returns the result.
// Writes shift memtable entries to open a hole; a flush copies the memtable entry by entry;
// a compaction applies each run entry to the base with a search and a shift of up to
// base_fill entries. One item at a time; done pulses one cycle per item
// and the receiver cannot stall it. Reset (async, rst_n low) empties the store, threshold 64.
module lsm_point_key_store (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [lsmpks_pkg::CMD_W-1:0]         command,
    input  logic [lsmpks_pkg::KEY_W-1:0]         key,
    input  logic [31:0]                          payload,
    output logic                                 done,
    output logic [lsmpks_pkg::STAT_W-1:0]        status,
    output logic                                 found,
    output logic [31:0]                          value_out,
    output logic [6:0]                           mem_count,
    output logic [2:0]                           run_count,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lsmpks_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    logic [lsmpks_pkg::THR_W-1:0] thr_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= lsmpks_pkg::THR_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == lsmpks_pkg::CFG_THRESHOLD)
        begin
            thr_reg <= pwdata[lsmpks_pkg::THR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == lsmpks_pkg::CFG_THRESHOLD) ? 32'(thr_reg) : 32'd0;

    lsmpks_pkg::run_req_t             run_req;
    lsmpks_pkg::base_req_t            base_req;
    logic [lsmpks_pkg::RUN_W-1:0]     run_rdata;
    logic [lsmpks_pkg::BASE_W-1:0]    base_rdata;

    // Memtable and small runs share one RAM, one slot each
    lsmpks_ram #(
        .WIDTH (lsmpks_pkg::RUN_W),
        .DEPTH (lsmpks_pkg::RUN_DEPTH)
    ) u_run_ram (
        .clk   (clk),
        .we    (run_req.we),
        .waddr (run_req.waddr),
        .wdata (run_req.wdata),
        .raddr (run_req.raddr),
        .rdata (run_rdata)
    );

    // Compacted base run
    lsmpks_ram #(
        .WIDTH (lsmpks_pkg::BASE_W),
        .DEPTH (lsmpks_pkg::BASE_CAP)
    ) u_base_ram (
        .clk   (clk),
        .we    (base_req.we),
        .waddr (base_req.waddr),
        .wdata (base_req.wdata),
        .raddr (base_req.raddr),
        .rdata (base_rdata)
    );

    lsmpks_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .command    (command),
        .key        (key),
        .payload    (payload),
        .thr        (thr_reg),
        .busy       (busy),
        .done       (done),
        .status     (status),
        .found      (found),
        .value_out  (value_out),
        .mem_count  (mem_count),
        .run_count  (run_count),
        .run_req    (run_req),
        .run_rdata  (run_rdata),
        .base_req   (base_req),
        .base_rdata (base_rdata)
    );

endmodule
